FILE: sv/brb_pkg.sv
// Shared constants for the byte ring buffer.
`default_nettype none
package brb_pkg;
	localparam int BYTE_W      = 8;
	localparam int STEP_W      = $clog2(BYTE_W);
	localparam int DEPTH_DEF   = 256;
	localparam int ACT_W       = 2;
	localparam int CAP_RESET   = 255;
	localparam int PADDR_W     = 2;
	localparam int PDATA_W     = 32;

	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

	localparam logic [PADDR_W-1:0] ADDR_CAP = 2'd0;
endpackage
`default_nettype wire

FILE: sv/byte_ring_buffer_with_peek.sv
// Byte ring buffer with peek: top level, control and status.
// Steps from start to done: write, clear and empty read finish in the execute state;
// a read then reads the store; peek first runs the 8-step bit-serial offset remainder, then one store read.
// One request at a time (start is taken only while busy is low); done lasts one cycle, no stall.
// After reset the store is zeroed by a pass over all STORE_DEPTH entries with busy high;
// capacity resets to 255 (clamped to STORE_DEPTH), both positions to zero.
`default_nettype none
module byte_ring_buffer_with_peek
	import brb_pkg::*;
#(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output      logic [PDATA_W-1:0] prdata,
	output      logic               pready,
	input  wire logic               start,
	output      logic               busy,
	input  wire logic [ACT_W-1:0]   action,
	input  wire logic [BYTE_W-1:0]  write_byte,
	input  wire logic [BYTE_W-1:0]  peek_offset,
	output      logic               done,
	output      logic [BYTE_W-1:0]  data_out,
	output      logic               write_dropped,
	output      logic [BYTE_W-1:0]  stored_count,
	output      logic               is_full,
	output      logic               is_empty
);
	localparam int PW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH+1);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_RDATA = 3'd4;

	function automatic logic [PW-1:0] adv(input logic [PW-1:0] pos, input logic [CW-1:0] c);
		logic [CW-1:0] n;
		n = CW'(pos) + CW'(1);
		return (n >= c) ? '0 : n[PW-1:0];
	endfunction

	logic [2:0]        state_q;
	logic [PW-1:0]     clr_q;
	logic [BYTE_W-1:0] cap_q;
	logic [PW-1:0]     rp_q;
	logic [PW-1:0]     wp_q;
	logic [ACT_W-1:0]  act_q;
	logic [BYTE_W-1:0] wbyte_q;
	logic [BYTE_W-1:0] off_q;
	logic              done_q;
	logic [BYTE_W-1:0] data_q;
	logic              dropped_q;

	logic [8:0]        cap_ext;
	logic [CW-1:0]     cap;
	logic              cfg_wr;
	logic              req;
	logic              full;
	logic              empty;
	logic [CW-1:0]     count;
	logic              mod_go;
	logic              mod_done;
	logic [PW-1:0]     mod_rem;
	logic [CW:0]       peek_sum;
	logic [PW-1:0]     peek_idx;
	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [PW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	always_comb begin
		cap_ext = {1'b0, cap_q};
		if (cap_ext < 9'd2) begin
			cap_ext = 9'd2;
		end else if (cap_ext > 9'(STORE_DEPTH)) begin
			cap_ext = 9'(STORE_DEPTH);
		end
		cap = cap_ext[CW-1:0];
	end

	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CAP);
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CAP) ? PDATA_W'(cap_q) : '0;

	assign busy  = (state_q != S_IDLE);
	assign req   = start && !busy;
	assign full  = (adv(wp_q, cap) == rp_q);
	assign empty = (rp_q == wp_q);
	assign count = (wp_q < rp_q) ? (cap - CW'(rp_q) + CW'(wp_q)) : CW'(wp_q - rp_q);

	assign mod_go   = (state_q == S_EXEC) && (act_q == ACT_PEEK);
	assign peek_sum = (CW+1)'(mod_rem) + (CW+1)'(rp_q);
	assign peek_idx = (peek_sum >= (CW+1)'(cap)) ? PW'(peek_sum - (CW+1)'(cap))
	                                             : PW'(peek_sum);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = wbyte_q;
		ram_raddr = rp_q;
		case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_EXEC: begin
				ram_we = (act_q == ACT_WRITE) && !full;
			end
			S_MOD: begin
				ram_raddr = peek_idx;
			end
			default: begin
			end
		endcase
	end

	brb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	brb_mod #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mod_go),
		.num   (off_q),
		.den   (cap),
		.done  (mod_done),
		.rem   (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cap_q   <= BYTE_W'(CAP_RESET);
			rp_q    <= '0;
			wp_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(STORE_DEPTH-1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						ACT_WRITE: begin
							if (!full) begin
								wp_q <= adv(wp_q, cap);
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						ACT_READ: begin
							if (empty) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_RDATA;
							end
						end
						ACT_PEEK: begin
							state_q <= S_MOD;
						end
						default: begin
							rp_q    <= '0;
							wp_q    <= '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_RDATA;
					end
				end
				S_RDATA: begin
					if (act_q == ACT_READ) begin
						rp_q <= adv(rp_q, cap);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_wr) begin
				cap_q <= pwdata[BYTE_W-1:0];
				rp_q  <= '0;
				wp_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			act_q   <= action;
			wbyte_q <= write_byte;
			off_q   <= peek_offset;
		end
		if (state_q == S_EXEC) begin
			data_q    <= '0;
			dropped_q <= (act_q == ACT_WRITE) && full;
		end else if (state_q == S_RDATA) begin
			data_q    <= ram_rdata;
			dropped_q <= 1'b0;
		end
	end

	assign done          = done_q;
	assign data_out      = data_q;
	assign write_dropped = dropped_q;
	assign stored_count  = BYTE_W'(count);
	assign is_full       = full;
	assign is_empty      = empty;
endmodule
`default_nettype wire

FILE: sv/brb_ram.sv
// Generic simple dual-port RAM, registered read.
`default_nettype none
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/brb_mod.sv
// Bit-serial remainder of a byte by the ring capacity.
`default_nettype none
module brb_mod
	import brb_pkg::*;
#(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             go,
	input  wire logic [BYTE_W-1:0]                num,
	input  wire logic [$clog2(STORE_DEPTH+1)-1:0] den,
	output      logic                             done,
	output      logic [$clog2(STORE_DEPTH)-1:0]   rem
);
	localparam int PW = $clog2(STORE_DEPTH);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [BYTE_W-1:0] num_q;
	logic [PW-1:0]     rem_q;
	logic [PW:0]       trial;
	logic [PW:0]       den_x;

	always_comb begin
		trial = {rem_q, num_q[BYTE_W-1]};
		den_x = (PW+1)'(den);
		if (trial >= den_x) begin
			trial = trial - den_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(BYTE_W-1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			rem_q <= trial[PW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the byte ring buffer with peek: directed and random requests.
module tb_top
	import brb_pkg::*;
();

	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              dropped;
		logic [BYTE_W-1:0] count;
		logic              full;
		logic              empty;
	} ring_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic [ACT_W-1:0]   action;
	logic [BYTE_W-1:0]  write_byte;
	logic [BYTE_W-1:0]  peek_offset;
	logic               done;
	logic [BYTE_W-1:0]  data_out;
	logic               write_dropped;
	logic [BYTE_W-1:0]  stored_count;
	logic               is_full;
	logic               is_empty;

	byte_ring_buffer_with_peek dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.write_byte   (write_byte),
		.peek_offset  (peek_offset),
		.done         (done),
		.data_out     (data_out),
		.write_dropped(write_dropped),
		.stored_count (stored_count),
		.is_full      (is_full),
		.is_empty     (is_empty)
	);

	// predicted ring state
	logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
	logic [BYTE_W-1:0] cap_reg;
	int unsigned       rd_pos;
	int unsigned       wr_pos;

	ring_result_t pending_results [$];
	ring_result_t last_result;
	ring_result_t head;
	bit           quiet;
	int           errors;
	int           sent_cnt;
	int           checked_cnt;
	int           drop_cnt;
	int           empty_read_cnt;
	int           cfg_writes;
	int           cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic int unsigned step_pos(input int unsigned pos, input int unsigned cap);
		return (pos + 1 >= cap) ? 0 : pos + 1;
	endfunction

	function automatic ring_result_t ring_predict(input logic [ACT_W-1:0] act,
			input logic [BYTE_W-1:0] wb, input logic [BYTE_W-1:0] off);
		int unsigned  cap;
		int unsigned  cnt;
		ring_result_t r;
		cap = (cap_reg < 2) ? 2 : cap_reg;
		if (rd_pos >= cap)
			rd_pos = 0;
		if (wr_pos >= cap)
			wr_pos = 0;
		r = '0;
		case (act)
			ACT_WRITE: begin
				if (step_pos(wr_pos, cap) == rd_pos) begin
					r.dropped = 1'b1;
					drop_cnt++;
				end else begin
					ring_mem[wr_pos] = wb;
					wr_pos = step_pos(wr_pos, cap);
				end
			end
			ACT_READ: begin
				if (rd_pos != wr_pos) begin
					r.data = ring_mem[rd_pos];
					rd_pos = step_pos(rd_pos, cap);
				end else begin
					empty_read_cnt++;
				end
			end
			ACT_PEEK: r.data = ring_mem[(off + rd_pos) % cap];
			default: begin
				rd_pos = 0;
				wr_pos = 0;
			end
		endcase
		cnt = (wr_pos < rd_pos) ? cap - rd_pos + wr_pos : wr_pos - rd_pos;
		r.count = cnt[BYTE_W-1:0];
		r.full  = (step_pos(wr_pos, cap) == rd_pos);
		r.empty = (rd_pos == wr_pos);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual data %0h count %0d",
					$time, data_out, stored_count);
			end else begin
				head = pending_results.pop_front();
				check_field("data_out", head.data, data_out);
				check_field("write_dropped", head.dropped, write_dropped);
				check_field("stored_count", head.count, stored_count);
				check_field("is_full", head.full, is_full);
				check_field("is_empty", head.empty, is_empty);
				checked_cnt++;
			end
		end
	end

	task automatic send_request(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] wb,
			input logic [BYTE_W-1:0] off);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start       <= 1'b1;
		action      <= act;
		write_byte  <= wb;
		peek_offset <= off;
		do @(posedge clk); while (busy);
		last_result = ring_predict(act, wb, off);
		pending_results.push_back(last_result);
		sent_cnt++;
	endtask

	// sender holds off until every pending result has come back
	task automatic wait_drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [PDATA_W-1:0] value);
		wait_drain();
		while (busy) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_CAP;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cap_reg = value[BYTE_W-1:0];
		rd_pos  = 0;
		wr_pos  = 0;
		cfg_writes++;
	endtask

	task automatic test_after_reset();
		send_request(ACT_PEEK, 8'h00, 8'h00);
		send_request(ACT_PEEK, 8'h00, 8'hFF);
		send_request(ACT_PEEK, 8'hFF, 8'h80);
		send_request(ACT_READ, 8'hFF, 8'h00);
		send_request(ACT_WRITE, 8'h00, 8'hFF);
		send_request(ACT_WRITE, 8'hFF, 8'h00);
		send_request(ACT_PEEK, 8'h00, 8'h01);
		send_request(ACT_PEEK, 8'h00, 8'hFE);
		send_request(ACT_READ, 8'h00, 8'h00);
		send_request(ACT_READ, 8'h00, 8'h00);
		send_request(ACT_READ, 8'h00, 8'h00);
		send_request(ACT_CLEAR, 8'hFF, 8'hFF);
		send_request(ACT_WRITE, 8'h3C, 8'h00);
		send_request(ACT_CLEAR, 8'h00, 8'h00);
	endtask

	// capacities 0 and 1 behave as 2; store keeps old bytes across the write
	task automatic test_tiny_capacity();
		write_capacity(32'h0000_0000);
		send_request(ACT_WRITE, 8'hA5, 8'h00);
		send_request(ACT_WRITE, 8'h5A, 8'h00);
		send_request(ACT_PEEK, 8'h00, 8'h00);
		send_request(ACT_PEEK, 8'h00, 8'hFF);
		send_request(ACT_READ, 8'h00, 8'h00);
		send_request(ACT_READ, 8'h00, 8'h00);
		write_capacity(32'hFFFF_FF01);
		send_request(ACT_WRITE, 8'h7E, 8'h00);
		send_request(ACT_CLEAR, 8'h00, 8'h00);
	endtask

	// fill/drain sequences with random content, noise mixed in
	task automatic rand_phase(input logic [PDATA_W-1:0] cap_value, input int n_req,
			input int peek_pct, input int minor_pct, input int clear_pct);
		bit               filling;
		int               r;
		logic [ACT_W-1:0] act;
		write_capacity(cap_value);
		filling = 1'b1;
		for (int i = 0; i < n_req; i++) begin
			r = $urandom_range(0, 99);
			if (r < clear_pct)
				act = ACT_CLEAR;
			else if (r < clear_pct + peek_pct)
				act = ACT_PEEK;
			else if (r < clear_pct + peek_pct + minor_pct)
				act = filling ? ACT_READ : ACT_WRITE;
			else
				act = filling ? ACT_WRITE : ACT_READ;
			send_request(act, BYTE_W'($urandom_range(0, 255)),
				BYTE_W'($urandom_range(0, 255)));
			if (filling && last_result.full && $urandom_range(0, 2) == 0)
				filling = 1'b0;
			else if (!filling && last_result.empty && $urandom_range(0, 2) == 0)
				filling = 1'b1;
		end
		wait_drain();
	endtask

	task automatic test_random_small();
		rand_phase(32'd2, 30, 15, 10, 2);
		quiet = 1'b1;
		rand_phase(32'd3, 30, 15, 10, 2);
		quiet = 1'b0;
		rand_phase($urandom_range(4, 16), 40, 15, 10, 2);
	endtask

	task automatic test_fill_largest();
		rand_phase(($urandom() & 32'hFFFF_FF00) | 32'd255, 290, 6, 2, 0);
	endtask

	task automatic test_random_mid();
		rand_phase($urandom_range(17, 254), 30, 15, 10, 2);
		rand_phase(32'd128, 20, 15, 10, 2);
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		start       = 1'b0;
		action      = ACT_WRITE;
		write_byte  = '0;
		peek_offset = '0;
		cap_reg     = BYTE_W'(CAP_RESET);
		rd_pos      = 0;
		wr_pos      = 0;
		quiet       = 1'b0;
		errors      = 0;
		sent_cnt    = 0;
		checked_cnt = 0;
		drop_cnt    = 0;
		empty_read_cnt = 0;
		cfg_writes  = 0;
		cycle_cnt   = 0;
		for (int i = 0; i < DEPTH_DEF; i++)
			ring_mem[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_tiny_capacity();
		test_random_small();
		test_fill_largest();
		test_random_mid();

		wait_drain();
		repeat (20) @(posedge clk);
		$display("Ran %0d requests (%0d results checked) over %0d capacity writes,",
			sent_cnt, checked_cnt, cfg_writes);
		$display("with %0d writes dropped on a full ring and %0d reads of an empty ring.",
			drop_cnt, empty_read_cnt);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
